// ----- rtl/core/bbpt_pkg.sv -----
// bbpt_pkg: shared types and constants for the back-to-back pair trigger.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package bbpt_pkg;

    // Field widths of the hit and result words
    localparam int TIME_W   = 48;
    localparam int ANGLE_W  = 15;
    localparam int FIDX_W   = 5;
    localparam int TOTAL_W  = 6;

    // Configuration registers
    localparam int TOL_W     = 14;
    localparam int WIN_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WIN  = 1'd1;

    localparam logic [TOL_W-1:0] ANGLE_TOL_RST = 14'd640;
    localparam logic [WIN_W-1:0] TIME_WIN_RST  = 24'd1000;

    // Angles in 1/64 degree
    localparam int FULL_TURN = 23040;
    localparam int HALF_TURN = 11520;

    localparam int MAX_HITS_DEF = 32;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_CALC,
        S_TEST,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/bbpt_if.sv -----
// bbpt_if: valid/ready channel interfaces for hit words and result words.
// Depends on bbpt_pkg for field widths.
`default_nettype none

interface bbpt_hit_if;
    logic                          valid;
    logic                          ready;
    logic [bbpt_pkg::TIME_W-1:0]   hit_time;
    logic [bbpt_pkg::ANGLE_W-1:0]  slot_angle;
    logic                          last_hit;

    modport source (output valid, hit_time, slot_angle, last_hit, input ready);
    modport sink   (input valid, hit_time, slot_angle, last_hit, output ready);
endinterface

interface bbpt_res_if;
    logic                          valid;
    logic                          ready;
    logic                          pair_found;
    logic [bbpt_pkg::FIDX_W-1:0]   first_index;
    logic [bbpt_pkg::FIDX_W-1:0]   second_index;
    logic [bbpt_pkg::TOTAL_W-1:0]  hit_total;
    logic                          hits_dropped;

    modport source (output valid, pair_found, first_index, second_index, hit_total,
                    hits_dropped, input ready);
    modport sink   (input valid, pair_found, first_index, second_index, hit_total,
                    hits_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bbpt_pair_cmp.sv -----
// bbpt_pair_cmp: shared pair test - time difference and wrapped angular separation.
// Depends on bbpt_pkg for widths and turn constants.
`default_nettype none

module bbpt_pair_cmp (
    input  wire logic [bbpt_pkg::TIME_W-1:0]  i_time_a,
    input  wire logic [bbpt_pkg::TIME_W-1:0]  i_time_b,
    input  wire logic [bbpt_pkg::ANGLE_W-1:0] i_angle_a,
    input  wire logic [bbpt_pkg::ANGLE_W-1:0] i_angle_b,
    input  wire logic [bbpt_pkg::TOL_W-1:0]   i_tolerance,
    input  wire logic [bbpt_pkg::WIN_W-1:0]   i_window,
    output logic                              o_match
);

    localparam int SW = bbpt_pkg::ANGLE_W + 2;

    logic [bbpt_pkg::TIME_W-1:0]  w_dt;
    logic [bbpt_pkg::ANGLE_W-1:0] w_d;
    logic signed [SW-1:0]         w_dext;
    logic signed [SW-1:0]         w_wrap;
    logic signed [SW-1:0]         w_sep;
    logic signed [SW-1:0]         w_dev;
    logic [SW-1:0]                w_adev;
    logic                         w_time_ok;
    logic                         w_angle_ok;

    always_comb begin
        w_dt   = (i_time_a > i_time_b) ? (i_time_a - i_time_b) : (i_time_b - i_time_a);
        w_d    = (i_angle_a > i_angle_b) ? (i_angle_a - i_angle_b)
                                         : (i_angle_b - i_angle_a);
        w_dext = $signed({2'b00, w_d});
        // may go negative for angles past a full turn
        w_wrap = $signed(SW'(bbpt_pkg::FULL_TURN)) - w_dext;
        w_sep  = (w_dext < w_wrap) ? w_dext : w_wrap;
        w_dev  = w_sep - $signed(SW'(bbpt_pkg::HALF_TURN));
        w_adev = w_dev[SW-1] ? unsigned'(-w_dev) : unsigned'(w_dev);
        w_time_ok  = w_dt < {{(bbpt_pkg::TIME_W-bbpt_pkg::WIN_W){1'b0}}, i_window};
        w_angle_ok = w_adev < {{(SW-bbpt_pkg::TOL_W){1'b0}}, i_tolerance};
        o_match    = w_time_ok && w_angle_ok;
    end

endmodule

`default_nettype wire

// ----- rtl/core/back_to_back_pair_trigger.sv -----
// back_to_back_pair_trigger: top level - hit buffer, pair scan sequencer, result register.
// Depends on bbpt_pkg, bbpt_if (hit/result channels) and bbpt_pair_cmp.
//
//  channel   dir  handshake          word
//  --------  ---  -----------------  ---------------------------------------------
//  i_hit     in   valid/ready        hit_time, slot_angle, last_hit
//  o_res     out  valid/ready        pair_found, first/second_index, hit_total,
//                                    hits_dropped
//  i_cfg_*   in   write enable only  register index, data (no read-back)
//
//  Sequence: a hit word is taken in any cycle in which i_hit.ready is high. After
//  the last hit the scan steps through S_READ (read buffer), S_CALC (compare) and
//  S_TEST (step the pair counters) for each pair it tests, then S_DONE hands the
//  result to the output register; an event of fewer than two hits goes straight
//  to S_DONE. The two-port read of the hit buffer and the single shared pair
//  comparator set this sequence. i_hit.ready is low for the whole scan.
//  Reset (synchronous, active low) clears the sequencer, hit count, drop flag,
//  result valid and configuration; buffer contents are left as they are.
//  A result waiting on o_res does not hold off the next event's hits; only a
//  scan finishing while the output register is still full waits.
`default_nettype none

module back_to_back_pair_trigger #(
    parameter int MAX_HITS = bbpt_pkg::MAX_HITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    bbpt_hit_if.sink                                i_hit,
    bbpt_res_if.source                              o_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [bbpt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bbpt_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int EW = bbpt_pkg::TIME_W + bbpt_pkg::ANGLE_W;

    // configuration
    logic [bbpt_pkg::TOL_W-1:0] r_tolerance;
    logic [bbpt_pkg::WIN_W-1:0] r_window;

    // sequencer
    bbpt_pkg::t_state r_state;
    bbpt_pkg::t_state n_state;

    logic [CW-1:0] r_count;
    logic [CW-1:0] w_count_new;
    logic          r_ovf;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic          r_found;
    logic          r_match;

    // hit buffer: {time, angle}
    logic [EW-1:0] r_mem [MAX_HITS];
    logic [EW-1:0] r_rd_a;
    logic [EW-1:0] r_rd_b;

    logic w_hit_acc;
    logic w_room;
    logic w_mem_we;
    logic w_out_load;
    logic w_j_more;
    logic w_i_more;
    logic w_match;

    // result register
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [bbpt_pkg::FIDX_W-1:0]   r_out_first;
    logic [bbpt_pkg::FIDX_W-1:0]   r_out_second;
    logic [bbpt_pkg::TOTAL_W-1:0]  r_out_total;
    logic                          r_out_dropped;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= bbpt_pkg::ANGLE_TOL_RST;
            r_window    <= bbpt_pkg::TIME_WIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbpt_pkg::REG_ANGLE_TOL: r_tolerance <= i_cfg_data[bbpt_pkg::TOL_W-1:0];
                bbpt_pkg::REG_TIME_WIN:  r_window    <= i_cfg_data[bbpt_pkg::WIN_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------- helpers
    always_comb begin
        w_hit_acc   = i_hit.valid && (r_state == bbpt_pkg::S_LOAD);
        w_room      = r_count < CW'(MAX_HITS);
        w_count_new = w_room ? (r_count + CW'(1)) : r_count;
        // another j for this i, else another i with at least one partner
        w_j_more    = (CW'(r_j) + CW'(1)) < r_count;
        w_i_more    = (CW'(r_i) + CW'(2)) < r_count;
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbpt_pkg::S_LOAD: begin
                if (w_hit_acc && i_hit.last_hit) begin
                    n_state = (w_count_new < CW'(2)) ? bbpt_pkg::S_DONE : bbpt_pkg::S_READ;
                end
            end
            bbpt_pkg::S_READ: n_state = bbpt_pkg::S_CALC;
            bbpt_pkg::S_CALC: n_state = bbpt_pkg::S_TEST;
            bbpt_pkg::S_TEST: begin
                if (r_match || (!w_j_more && !w_i_more)) begin
                    n_state = bbpt_pkg::S_DONE;
                end else begin
                    n_state = bbpt_pkg::S_READ;
                end
            end
            bbpt_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = bbpt_pkg::S_LOAD;
                end
            end
            default: n_state = bbpt_pkg::S_LOAD;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        i_hit.ready = (r_state == bbpt_pkg::S_LOAD);
        w_mem_we    = w_hit_acc && w_room;
        w_out_load  = (r_state == bbpt_pkg::S_DONE) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbpt_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- hit buffer
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IW-1:0]] <= {i_hit.hit_time, i_hit.slot_angle};
        end
        if (r_state == bbpt_pkg::S_READ) begin
            r_rd_a <= r_mem[r_i];
            r_rd_b <= r_mem[r_j];
        end
    end

    // ---------------------------------------------------------------- count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_out_load) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_hit_acc) begin
            r_count <= w_count_new;
            if (!w_room) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- shared pair test
    bbpt_pair_cmp u_cmp (
        .i_time_a    (r_rd_a[EW-1:bbpt_pkg::ANGLE_W]),
        .i_time_b    (r_rd_b[EW-1:bbpt_pkg::ANGLE_W]),
        .i_angle_a   (r_rd_a[bbpt_pkg::ANGLE_W-1:0]),
        .i_angle_b   (r_rd_b[bbpt_pkg::ANGLE_W-1:0]),
        .i_tolerance (r_tolerance),
        .i_window    (r_window),
        .o_match     (w_match)
    );

    // pair counters, i < j, j runs fastest
    always_ff @(posedge i_clk) begin
        if (r_state == bbpt_pkg::S_CALC) begin
            r_match <= w_match;
        end
        if (w_hit_acc && i_hit.last_hit) begin
            r_i     <= '0;
            r_j     <= IW'(1);
            r_found <= 1'b0;
        end else if (r_state == bbpt_pkg::S_TEST) begin
            if (r_match) begin
                r_found <= 1'b1;
            end else if (w_j_more) begin
                r_j <= r_j + IW'(1);
            end else if (w_i_more) begin
                r_i <= r_i + IW'(1);
                r_j <= r_i + IW'(2);
            end
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found   <= r_found;
            r_out_first   <= r_found ? bbpt_pkg::FIDX_W'(r_i) : '0;
            r_out_second  <= r_found ? bbpt_pkg::FIDX_W'(r_j) : '0;
            r_out_total   <= bbpt_pkg::TOTAL_W'(r_count);
            r_out_dropped <= r_ovf;
        end
    end

    always_comb begin
        o_res.valid        = r_out_valid;
        o_res.pair_found   = r_out_found;
        o_res.first_index  = r_out_first;
        o_res.second_index = r_out_second;
        o_res.hit_total    = r_out_total;
        o_res.hits_dropped = r_out_dropped;
    end

endmodule

`default_nettype wire

// ----- rtl/core/bbpt_checker.sv -----
// bbpt_checker: port-level assertions on the result channel, bound to the top level.
// Depends on bbpt_pkg for field widths.
`default_nettype none

module bbpt_checker #(
    parameter int MAX_HITS = bbpt_pkg::MAX_HITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_pair_found,
    input wire logic [bbpt_pkg::FIDX_W-1:0]   i_first_index,
    input wire logic [bbpt_pkg::FIDX_W-1:0]   i_second_index,
    input wire logic [bbpt_pkg::TOTAL_W-1:0]  i_hit_total,
    input wire logic                          i_hits_dropped
);

    localparam bit IDX_FITS = (MAX_HITS <= 32);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pair_found)
            && $stable(i_first_index) && $stable(i_second_index)
            && $stable(i_hit_total) && $stable(i_hits_dropped))
        else $error("result word changed while stalled");

    // a reported pair is ordered
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pair_found && IDX_FITS |-> i_first_index < i_second_index)
        else $error("pair indices out of order");

    // no pair reports zero indices
    a_no_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_pair_found |-> i_first_index == '0 && i_second_index == '0)
        else $error("indices set without a pair");

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind back_to_back_pair_trigger bbpt_checker #(.MAX_HITS(MAX_HITS)) u_bbpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_pair_found   (o_res.pair_found),
    .i_first_index  (o_res.first_index),
    .i_second_index (o_res.second_index),
    .i_hit_total    (o_res.hit_total),
    .i_hits_dropped (o_res.hits_dropped)
);

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for back_to_back_pair_trigger.
// Uses bbpt_pkg, the bbpt_hit_if / bbpt_res_if channels and the block itself.
// A predictor runs alongside, and every result word is checked field by field.

module tb;

    localparam int TIME_W    = bbpt_pkg::TIME_W;
    localparam int ANGLE_W   = bbpt_pkg::ANGLE_W;
    localparam int FIDX_W    = bbpt_pkg::FIDX_W;
    localparam int TOTAL_W   = bbpt_pkg::TOTAL_W;
    localparam int TOL_W     = bbpt_pkg::TOL_W;
    localparam int WIN_W     = bbpt_pkg::WIN_W;
    localparam int CFG_IDX_W = bbpt_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = bbpt_pkg::CFG_DAT_W;
    localparam int FULL_TURN = bbpt_pkg::FULL_TURN;
    localparam int HALF_TURN = bbpt_pkg::HALF_TURN;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = bbpt_pkg::REG_ANGLE_TOL;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WIN  = bbpt_pkg::REG_TIME_WIN;
    localparam logic [TOL_W-1:0]     ANGLE_TOL_RST = bbpt_pkg::ANGLE_TOL_RST;
    localparam logic [WIN_W-1:0]     TIME_WIN_RST  = bbpt_pkg::TIME_WIN_RST;

    localparam int MAX_HITS   = bbpt_pkg::MAX_HITS_DEF;
    localparam int PHASES     = 7;
    localparam int PHASE_HITS = 185;
    // Longest scan: every pair of a full buffer tested, plus handover
    localparam int SCAN_MAX   = 3 * (MAX_HITS * (MAX_HITS - 1) / 2) + 1;

    typedef struct packed {
        logic                found;
        logic [FIDX_W-1:0]   fi;
        logic [FIDX_W-1:0]   si;
        logic [TOTAL_W-1:0]  total;
        logic                dropped;
    } t_pair_res;

    // One row of the directed table; typed = expected word written in by hand
    typedef struct packed {
        logic [TIME_W-1:0]   t;
        logic [ANGLE_W-1:0]  a;
        logic                last;
        logic                typed;
        t_pair_res           res;
    } t_dir_row;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;

    bbpt_hit_if hit_ch ();
    bbpt_res_if res_ch ();

    back_to_back_pair_trigger dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_hit      (hit_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ---- predictor state: hit buffer, count, drop flag, register copies ----
    logic [TIME_W-1:0]  time_mem [MAX_HITS];
    logic [ANGLE_W-1:0] ang_mem  [MAX_HITS];
    int unsigned        hits_held;
    bit                 drop_seen;
    logic [TOL_W-1:0]   tol_reg;
    logic [WIN_W-1:0]   win_reg;

    t_pair_res pair_exp_q [$];
    int        err_cnt;
    int        hits_sent;

    // idling knobs, per cent of cycles; hold_req asks the receiver for a long hold-off
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[back_to_back_pair_trigger] ERROR");
        $finish;
    end

    // Back-to-back test: wrapped separation within tolerance of a half turn,
    // and time gap strictly inside the window. Separation is signed because an
    // angle past a full turn makes the wrapped term negative.
    function automatic bit is_pair(int unsigned a, int unsigned b);
        logic [TIME_W-1:0] dt;
        int d;
        int wrapped;
        int sep;
        int dev;
        dt = (time_mem[a] > time_mem[b]) ? time_mem[a] - time_mem[b]
                                         : time_mem[b] - time_mem[a];
        d = int'(ang_mem[a]) - int'(ang_mem[b]);
        if (d < 0) d = -d;
        wrapped = FULL_TURN - d;
        sep = (d < wrapped) ? d : wrapped;
        dev = sep - HALF_TURN;
        if (dev < 0) dev = -dev;
        return (dev < int'(tol_reg)) && (dt < TIME_W'(win_reg));
    endfunction

    // Store the hit (or note the drop); on the last hit scan the pairs in order
    task automatic predict_hit(input logic [TIME_W-1:0] t, input logic [ANGLE_W-1:0] a,
                               input logic last, output bit got, output t_pair_res r);
        int unsigned i;
        int unsigned j;
        bit found;
        got = 1'b0;
        r   = '0;
        if (hits_held < MAX_HITS) begin
            time_mem[hits_held] = t;
            ang_mem[hits_held]  = a;
            hits_held++;
        end else begin
            drop_seen = 1'b1;
        end
        if (last) begin
            found = 1'b0;
            for (i = 0; i < hits_held && !found; i++) begin
                for (j = i + 1; j < hits_held && !found; j++) begin
                    if (is_pair(i, j)) begin
                        found = 1'b1;
                        r.fi  = FIDX_W'(i);
                        r.si  = FIDX_W'(j);
                    end
                end
            end
            r.found   = found;
            r.total   = TOTAL_W'(hits_held);
            r.dropped = drop_seen;
            got       = 1'b1;
            hits_held = 0;
            drop_seen = 1'b0;
        end
    endtask

    // Offer one hit word, with a random gap first, and hold it until taken
    task automatic send_hit(input logic [TIME_W-1:0] t, input logic [ANGLE_W-1:0] a,
                            input logic last, input logic typed, input t_pair_res typed_res);
        bit got;
        t_pair_res p;
        while ($urandom_range(99) < send_idle_pct) begin
            hit_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hit_ch.valid      <= 1'b1;
        hit_ch.hit_time   <= t;
        hit_ch.slot_angle <= a;
        hit_ch.last_hit   <= last;
        @(posedge clk);
        while (!hit_ch.ready) @(posedge clk);
        predict_hit(t, a, last, got, p);
        if (got) pair_exp_q = {pair_exp_q, (typed ? typed_res : p)};
        hits_sent++;
    endtask

    // One event of random content: about half the hits are aimed opposite an earlier hit
    // of the event, near the tolerance edge and near the time window edge;
    // the rest are random slots, a few of them past a full turn.
    task automatic send_event(input int n_hits);
        logic [63:0]       raw;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] t;
        int ang [40];
        int k;
        int p;
        int v;
        int span;
        raw  = {$urandom, $urandom};
        base = ($urandom_range(9) == 0) ? 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(5000))
                                        : raw[TIME_W-1:0];
        span = (win_reg > 24'd1_000_000) ? 2_000_000 : int'(win_reg) * 3 / 2 + 4;
        for (k = 0; k < n_hits; k++) begin
            t = base + TIME_W'($urandom_range(span));
            if ($urandom_range(99) < 8) begin
                v = int'($urandom_range(32767));
            end else if (k == 0 || $urandom_range(1) == 0) begin
                v = int'($urandom_range(FULL_TURN - 1));
            end else begin
                p = int'($urandom_range(k - 1));
                v = ang[p] % FULL_TURN + HALF_TURN
                    + int'($urandom_range(2 * int'(tol_reg) + 4)) - (int'(tol_reg) + 2);
                v = v % FULL_TURN;
                if (v < 0) v += FULL_TURN;
            end
            ang[k] = v;
            send_hit(t, ANGLE_W'(v), k == n_hits - 1, 1'b0, '0);
        end
    endtask

    // Mostly small events; some mid-sized, some exactly full, some overflowing
    function automatic int pick_size();
        int r;
        r = int'($urandom_range(99));
        if (r < 75) return int'($urandom_range(1, 6));
        if (r < 90) return int'($urandom_range(7, MAX_HITS - 1));
        if (r < 95) return MAX_HITS;
        return int'($urandom_range(MAX_HITS + 1, 40));
    endfunction

    // Both registers, back to back; only called with the block idle
    task automatic set_config(input logic [TOL_W-1:0] tol, input logic [WIN_W-1:0] win);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_ANGLE_TOL;
        cfg_data <= CFG_DAT_W'(tol);
        @(posedge clk);
        tol_reg  = tol;
        cfg_idx  <= REG_TIME_WIN;
        cfg_data <= win;
        @(posedge clk);
        win_reg  = win;
        cfg_we   <= 1'b0;
    endtask

    // Stop offering, wait for every pending result, then let the block settle
    task automatic drain(input int settle);
        hit_ch.valid <= 1'b0;
        while (pair_exp_q.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // ---- result side: check each accepted word, then drive ready ----
    initial begin
        int hold_left;
        t_pair_res want;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                if (pair_exp_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, got found=%0d %0d/%0d",
                             $time, res_ch.pair_found, res_ch.first_index,
                             res_ch.second_index);
                    err_cnt++;
                end else begin
                    want = pair_exp_q.pop_front();
                    report_field("pair_found",   want.found,   res_ch.pair_found);
                    report_field("first_index",  want.fi,      res_ch.first_index);
                    report_field("second_index", want.si,      res_ch.second_index);
                    report_field("hit_total",    want.total,   res_ch.hit_total);
                    report_field("hits_dropped", want.dropped, res_ch.hits_dropped);
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---- main sequence ----
    initial begin
        t_dir_row dir_tab [23];
        int ph_tol  [PHASES];
        int ph_win  [PHASES];
        int ph_send [PHASES];
        int ph_recv [PHASES];
        int ph_hold [PHASES];
        logic [63:0] raw;
        int k;
        int ph;
        int start;

        hit_ch.valid      <= 1'b0;
        hit_ch.hit_time   <= '0;
        hit_ch.slot_angle <= '0;
        hit_ch.last_hit   <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_ANGLE_TOL;
        cfg_data          <= '0;
        rst_n             <= 1'b0;

        hits_held      = 0;
        drop_seen      = 1'b0;
        tol_reg        = ANGLE_TOL_RST;
        win_reg        = TIME_WIN_RST;
        err_cnt        = 0;
        hits_sent      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings (tolerance 640, window 1000).
        //          time               angle  last typed   found fi si total drop
        dir_tab = '{
            // lone hit: no pair possible
            '{48'd0,               15'd0,     1'b1, 1'b1, '{1'b1 ^ 1'b1, 5'd0, 5'd0, 6'd1, 1'b0}},
            // exactly opposite, well inside the window
            '{48'd100,             15'd0,     1'b0, 1'b0, '0},
            '{48'd600,             15'd11520, 1'b1, 1'b1, '{1'b1, 5'd0, 5'd1, 6'd2, 1'b0}},
            // time gap equal to the window: rejected
            '{48'd1000,            15'd100,   1'b0, 1'b0, '0},
            '{48'd2000,            15'd11620, 1'b1, 1'b1, '{1'b0, 5'd0, 5'd0, 6'd2, 1'b0}},
            // top of the time range, top legal slot
            '{48'hFFFF_FFFF_FFFF,  15'd23039, 1'b0, 1'b0, '0},
            '{48'hFFFF_FFFF_FC18,  15'd11519, 1'b1, 1'b1, '{1'b1, 5'd0, 5'd1, 6'd2, 1'b0}},
            // deviation equal to the tolerance: rejected
            '{48'd5,               15'd0,     1'b0, 1'b0, '0},
            '{48'd5,               15'd12160, 1'b1, 1'b1, '{1'b0, 5'd0, 5'd0, 6'd2, 1'b0}},
            // one step inside the tolerance
            '{48'd5,               15'd0,     1'b0, 1'b0, '0},
            '{48'd5,               15'd12159, 1'b1, 1'b1, '{1'b1, 5'd0, 5'd1, 6'd2, 1'b0}},
            // slot past a full turn, all angle bits set
            '{48'd10,              15'd32767, 1'b0, 1'b0, '0},
            '{48'd20,              15'd16384, 1'b0, 1'b0, '0},
            '{48'd30,              15'd21247, 1'b1, 1'b0, '0},
            // first partner found only on a later j
            '{48'd0,               15'd5000,  1'b0, 1'b0, '0},
            '{48'd50,              15'd5000,  1'b0, 1'b0, '0},
            '{48'd60,              15'd16520, 1'b1, 1'b0, '0},
            // alternating bit patterns in time and angle
            '{48'h5555_5555_5555,  15'h2AAA,  1'b0, 1'b0, '0},
            '{48'hAAAA_AAAA_AAAA,  15'h5555,  1'b0, 1'b0, '0},
            '{48'h5555_5555_5800,  15'd22442, 1'b1, 1'b0, '0},
            // wrap-around: 100 and 22940 are close, not opposite
            '{48'd7,               15'd100,   1'b0, 1'b0, '0},
            '{48'd7,               15'd22940, 1'b0, 1'b0, '0},
            '{48'd7,               15'd11620, 1'b1, 1'b0, '0}
        };
        foreach (dir_tab[k])
            send_hit(dir_tab[k].t, dir_tab[k].a, dir_tab[k].last, dir_tab[k].typed,
                     dir_tab[k].res);

        // Overflow: 34 words, so the closing word itself is dropped yet ends the event
        for (k = 0; k < MAX_HITS + 2; k++) begin
            raw = {$urandom, $urandom};
            send_hit(raw[TIME_W-1:0], ANGLE_W'($urandom_range(32767)), k == MAX_HITS + 1,
                     1'b0, '0);
        end

        // Phases: settings and idling pattern per phase; phase 4 also holds the
        // receiver off long enough that the block backs up into the hit channel.
        ph_tol  = '{640, 0,  11520,    1, 0,   3000,   640};
        ph_win  = '{1000, 0, 16777215, 1, 0,   200000, 1000};
        ph_send = '{0,  64, 0,        30, 0,   64,     0};
        ph_recv = '{0,  0,  64,       30, 0,   0,      64};
        ph_hold = '{0,  0,  0,        0,  600, 0,      0};
        ph_tol[4] = int'($urandom_range(HALF_TURN));
        ph_win[4] = int'($urandom_range(5000));

        for (ph = 0; ph < PHASES; ph++) begin
            drain(8);
            set_config(TOL_W'(ph_tol[ph]), WIN_W'(ph_win[ph]));
            send_idle_pct  = ph_send[ph];
            recv_stall_pct = ph_recv[ph];
            hold_req       = ph_hold[ph];
            start          = hits_sent;
            while (hits_sent - start < PHASE_HITS)
                send_event(pick_size());
        end

        drain(SCAN_MAX + 16);
        if (err_cnt == 0)
            $display("[back_to_back_pair_trigger] OK");
        else
            $display("[back_to_back_pair_trigger] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bbpt_pkg.sv
rtl/core/bbpt_if.sv
rtl/core/bbpt_pair_cmp.sv
rtl/core/back_to_back_pair_trigger.sv
rtl/core/bbpt_checker.sv
verif/tb.sv
